### design/sspm_pkg.sv
// Shared constants, codes and word types of the state slot pool manager.
package sspm_pkg;

    // Pool dimensions
    localparam int ACTIVE_SLOTS = 16;
    localparam int CACHED_SLOTS = 16;

    // Cached arrays keep at least one entry so that an empty cache still elaborates
    localparam int CACH_N = (CACHED_SLOTS > 0) ? CACHED_SLOTS : 1;
    localparam int ACT_W  = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;
    localparam int CACH_W = (CACH_N > 1) ? $clog2(CACH_N) : 1;
    localparam int CNT_W  = $clog2(ACTIVE_SLOTS + 1);
    localparam int LEFT_W = (CACHED_SLOTS > 0) ? $clog2(CACHED_SLOTS + 1) : 1;
    localparam int SCAN_W = (ACT_W > CACH_W) ? ACT_W : CACH_W;

    // Field widths
    localparam int OP_W   = 3;
    localparam int ID_W   = 32;
    localparam int KEY_W  = 64;
    localparam int FR_W   = 8;
    localparam int TGT_W  = 8;
    localparam int STS_W  = 2;
    localparam int SLOT_W = 5;
    localparam int SOP_W  = 2;

    // Slot sums wide enough for the highest cached slot before masking
    localparam int SUM_W = ($clog2(ACTIVE_SLOTS + CACH_N) > SLOT_W) ?
                           $clog2(ACTIVE_SLOTS + CACH_N) : SLOT_W;

    localparam logic [FR_W-1:0] FRONTIER_RESET = FR_W'(16);

    // Opcodes
    localparam logic [OP_W-1:0] OP_ACQUIRE     = 3'd0;
    localparam logic [OP_W-1:0] OP_RELEASE     = 3'd1;
    localparam logic [OP_W-1:0] OP_FIND_ACTIVE = 3'd2;
    localparam logic [OP_W-1:0] OP_SNAPSHOT    = 3'd3;
    localparam logic [OP_W-1:0] OP_RESTORE     = 3'd4;
    localparam logic [OP_W-1:0] OP_FIND_CACHED = 3'd5;

    // Status codes
    localparam logic [STS_W-1:0] STS_OK      = 2'd0;
    localparam logic [STS_W-1:0] STS_INVALID = 2'd1;
    localparam logic [STS_W-1:0] STS_FULL    = 2'd2;

    // Storage commands
    localparam logic [SOP_W-1:0] SOP_NONE = 2'd0;
    localparam logic [SOP_W-1:0] SOP_ZERO = 2'd1;
    localparam logic [SOP_W-1:0] SOP_COPY = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [ID_W-1:0]  sequence_id;
        logic [KEY_W-1:0] prefix_key;
        logic [FR_W-1:0]  frontier_index;
        logic [TGT_W-1:0] target_slot;
    } t_cmd_word;

    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic [SOP_W-1:0]  storage_op;
        logic [SLOT_W-1:0] storage_src;
        logic [SLOT_W-1:0] storage_dst;
    } t_rsp_word;

endpackage

### design/sspm_if.sv
// Handshake channels of the state slot pool manager: command, response, config.
interface sspm_cmd_if import sspm_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cmd_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sspm_rsp_if import sspm_pkg::*; ();
    logic      valid;
    logic      ready;
    t_rsp_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sspm_cfg_if import sspm_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [FR_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/state_slot_pool_manager_top.sv
// Top level of the state slot pool manager: slot allocator with a scanned tag store.
//
//   channel  dir  payload                                          handshake
//   i_cmd    in   opcode, sequence_id, prefix_key, frontier/target valid/ready
//   o_rsp    out  status, found, slot, storage_op/src/dst          valid/ready
//   i_cfg    in   frontier limit (8 bits)                          valid/ready
//
// A command is accepted, then scanned with one tag compare per cycle over the
// owner ids or the cached keys (up to 16 entries, stops at the first hit), then a
// finish step updates the pool and loads the response register.
// i_cmd.ready is high only while idle; a config word is taken every cycle.
// Reset is synchronous; no clearing pass, used bits clear at once.
// A stalled response holds in the output register and holds back the finish step.
module state_slot_pool_manager_top import sspm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sspm_cmd_if.sink    i_cmd,
    sspm_rsp_if.source  o_rsp,
    sspm_cfg_if.sink    i_cfg
);

    t_state r_state, n_state;

    t_cmd_word         r_cmd;
    logic [SCAN_W-1:0] r_idx;
    logic              r_hit;
    logic [SCAN_W-1:0] r_hit_idx;
    logic [FR_W-1:0]   r_front_limit;

    logic [ACT_W-1:0]  r_free_stack [ACTIVE_SLOTS];
    logic [CNT_W-1:0]  r_free_count;
    logic [ID_W-1:0]   r_owner_id   [ACTIVE_SLOTS];
    logic [ACTIVE_SLOTS-1:0] r_owner_used;
    logic [KEY_W-1:0]  r_cached_key [CACH_N];
    logic [CACH_N-1:0] r_cached_used;
    logic [LEFT_W-1:0] r_cached_left;

    logic      r_out_valid;
    t_rsp_word r_out;

    // Control outputs of the sequencer
    logic cmd_take;
    logic scan_step;
    logic fin_fire;

    // Shared compare unit
    logic             is_key_op;
    logic [ACT_W-1:0] idx_a;
    logic [CACH_W-1:0] idx_c;
    logic             ent_hit;
    logic             scan_last;

    // Finish step
    t_rsp_word         res;
    logic              act_set;
    logic              act_clr;
    logic [ACT_W-1:0]  act_idx;
    logic              do_pop;
    logic              do_push;
    logic              do_cache;
    logic [CNT_W-1:0]  free_top;
    logic [ACT_W-1:0]  top_slot;
    logic [ACT_W-1:0]  pop_slot;
    logic [LEFT_W-1:0] left_m1;
    logic [ACT_W-1:0]  hit_a;
    logic [CACH_W-1:0] hit_c;
    logic [SUM_W-1:0]  cslot_hit;
    logic [SUM_W-1:0]  cslot_new;
    logic              tgt_ok;
    logic              fr_ok;

    // Config register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_limit <= FRONTIER_RESET;
        end else if (i_cfg.valid) begin
            r_front_limit <= i_cfg.data;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd.valid) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (ent_hit || scan_last) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (!r_out_valid || o_rsp.ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        cmd_take  = 1'b0;
        scan_step = 1'b0;
        fin_fire  = 1'b0;
        unique case (r_state)
            ST_IDLE:   cmd_take  = i_cmd.valid;
            ST_SCAN:   scan_step = 1'b1;
            ST_FINISH: fin_fire  = !r_out_valid || o_rsp.ready;
            default: ;
        endcase
    end

    assign i_cmd.ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Tag compare: one entry per cycle
    assign is_key_op = (r_cmd.opcode == OP_SNAPSHOT) || (r_cmd.opcode == OP_RESTORE) ||
                       (r_cmd.opcode == OP_FIND_CACHED);
    assign idx_a = r_idx[ACT_W-1:0];
    assign idx_c = r_idx[CACH_W-1:0];
    assign ent_hit = is_key_op ?
        (r_cached_used[idx_c] && (r_cached_key[idx_c] == r_cmd.prefix_key)) :
        (r_owner_used[idx_a] && (r_owner_id[idx_a] == r_cmd.sequence_id));
    assign scan_last = is_key_op ? (r_idx == SCAN_W'(CACH_N - 1)) :
                                   (r_idx == SCAN_W'(ACTIVE_SLOTS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
            r_idx <= '0;
        end else if (cmd_take) begin
            r_hit <= 1'b0;
            r_idx <= '0;
        end else if (scan_step) begin
            if (ent_hit) begin
                r_hit <= 1'b1;
            end else if (!scan_last) begin
                r_idx <= r_idx + SCAN_W'(1);
            end
        end
    end

    // Command and hit index payload
    always_ff @(posedge i_clk) begin
        if (cmd_take) r_cmd <= i_cmd.data;
        if (scan_step && ent_hit) r_hit_idx <= r_idx;
    end

    // Finish step: decide the response and the pool update
    assign free_top  = r_free_count - CNT_W'(1);
    assign top_slot  = r_free_stack[free_top[ACT_W-1:0]];
    assign pop_slot  = ({1'b0, top_slot} >= (ACT_W + 1)'(ACTIVE_SLOTS)) ? '0 : top_slot;
    assign left_m1   = r_cached_left - LEFT_W'(1);
    assign hit_a     = r_hit_idx[ACT_W-1:0];
    assign hit_c     = r_hit_idx[CACH_W-1:0];
    assign cslot_hit = SUM_W'(ACTIVE_SLOTS) + SUM_W'(hit_c);
    assign cslot_new = SUM_W'(ACTIVE_SLOTS) + SUM_W'(left_m1);
    assign tgt_ok    = ({1'b0, r_cmd.target_slot} < (TGT_W + 1)'(ACTIVE_SLOTS));
    assign fr_ok     = (r_cmd.frontier_index < r_front_limit);

    always_comb begin
        res      = '0;
        act_set  = 1'b0;
        act_clr  = 1'b0;
        act_idx  = hit_a;
        do_pop   = 1'b0;
        do_push  = 1'b0;
        do_cache = 1'b0;
        case (r_cmd.opcode)
            OP_ACQUIRE: begin
                if (r_hit) begin
                    res.found = 1'b1;
                    res.slot  = SLOT_W'(hit_a);
                end else if ((r_free_count == '0) ||
                             (r_free_count > CNT_W'(ACTIVE_SLOTS))) begin
                    res.status = STS_FULL;
                end else begin
                    do_pop          = 1'b1;
                    act_set         = 1'b1;
                    act_idx         = pop_slot;
                    res.found       = 1'b1;
                    res.slot        = SLOT_W'(pop_slot);
                    res.storage_op  = SOP_ZERO;
                    res.storage_dst = SLOT_W'(pop_slot);
                end
            end
            OP_RELEASE: begin
                if (r_hit) begin
                    act_clr   = 1'b1;
                    do_push   = (r_free_count < CNT_W'(ACTIVE_SLOTS));
                    res.found = 1'b1;
                    res.slot  = SLOT_W'(hit_a);
                end
            end
            OP_FIND_ACTIVE: begin
                if (r_hit) begin
                    res.found = 1'b1;
                    res.slot  = SLOT_W'(hit_a);
                end
            end
            OP_SNAPSHOT: begin
                if (!tgt_ok || !fr_ok) begin
                    res.status = STS_INVALID;
                end else if (r_hit) begin
                    res.found = 1'b1;
                    res.slot  = cslot_hit[SLOT_W-1:0];
                end else if ((r_cached_left == '0) ||
                             (r_cached_left > LEFT_W'(CACHED_SLOTS))) begin
                    res.status = STS_FULL;
                end else begin
                    do_cache        = 1'b1;
                    res.found       = 1'b1;
                    res.slot        = cslot_new[SLOT_W-1:0];
                    res.storage_op  = SOP_COPY;
                    res.storage_src = r_cmd.target_slot[SLOT_W-1:0];
                    res.storage_dst = cslot_new[SLOT_W-1:0];
                end
            end
            OP_RESTORE: begin
                if (!tgt_ok || !r_hit) begin
                    res.status = STS_INVALID;
                end else begin
                    res.found       = 1'b1;
                    res.slot        = cslot_hit[SLOT_W-1:0];
                    res.storage_op  = SOP_COPY;
                    res.storage_src = cslot_hit[SLOT_W-1:0];
                    res.storage_dst = r_cmd.target_slot[SLOT_W-1:0];
                end
            end
            OP_FIND_CACHED: begin
                if (r_hit) begin
                    res.found = 1'b1;
                    res.slot  = cslot_hit[SLOT_W-1:0];
                end
            end
            default: res.status = STS_INVALID;
        endcase
    end

    // Pool state with reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ACTIVE_SLOTS; i++) begin
                r_free_stack[i] <= ACT_W'(i);
            end
            r_free_count  <= CNT_W'(ACTIVE_SLOTS);
            r_owner_used  <= '0;
            r_cached_used <= '0;
            r_cached_left <= LEFT_W'(CACHED_SLOTS);
        end else if (fin_fire) begin
            if (do_pop) r_free_count <= free_top;
            if (do_push) begin
                r_free_stack[r_free_count[ACT_W-1:0]] <= hit_a;
                r_free_count <= r_free_count + CNT_W'(1);
            end
            if (act_set) r_owner_used[act_idx] <= 1'b1;
            if (act_clr) r_owner_used[act_idx] <= 1'b0;
            if (do_cache) begin
                r_cached_used[left_m1[CACH_W-1:0]] <= 1'b1;
                r_cached_left <= left_m1;
            end
        end
    end

    // Tag stores, valid only where the used bit is set
    always_ff @(posedge i_clk) begin
        if (fin_fire && act_set) r_owner_id[act_idx] <= r_cmd.sequence_id;
        if (fin_fire && do_cache) r_cached_key[left_m1[CACH_W-1:0]] <= r_cmd.prefix_key;
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_fire) r_out <= res;
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

endmodule

### sim/state_slot_pool_manager_top_tb.sv
// Self-checking testbench for the state slot pool manager: directed table, then random traffic.
module state_slot_pool_manager_top_tb;
    import sspm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Opcodes the block must reject
    localparam logic [OP_W-1:0] OP_RSVD_A = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_B = 3'd7;

    localparam int HOLD_CYCLES  = 300;   // long response hold-off
    localparam int DRAIN_CYCLES = 24;    // covers the worst case command
    localparam int STALL_LIMIT  = 3000;  // cycles with no word moving
    localparam int POOL_IDS     = 20;
    localparam int POOL_KEYS    = 20;
    localparam int PHASE_ITEMS  = 150;

    typedef struct {
        t_cmd_word cmd;
        bit        fixed;
        t_rsp_word rsp;
    } t_dir_row;

    logic clk;
    logic rst_n;

    sspm_cmd_if cmd_ch ();
    sspm_rsp_if rsp_ch ();
    sspm_cfg_if cfg_ch ();

    state_slot_pool_manager_top uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    // Shadow copy of the pool
    logic [FR_W-1:0]  depth_cfg;
    logic [ACT_W-1:0] free_slots [ACTIVE_SLOTS];
    int               free_top;
    logic [ID_W-1:0]  bound_id   [ACTIVE_SLOTS];
    bit               bound_used [ACTIVE_SLOTS];
    logic [KEY_W-1:0] snap_key   [CACHED_SLOTS];
    bit               snap_used  [CACHED_SLOTS];
    int               snap_left;

    t_rsp_word pool_rsp_q [$];
    t_dir_row  dir_rows [$];

    // Word the driver is currently offering and whether its response is typed in
    bit        row_fixed;
    t_rsp_word row_rsp;

    logic [ID_W-1:0]  id_pool  [POOL_IDS];
    logic [KEY_W-1:0] key_pool [POOL_KEYS];

    int  cmd_gap_pct;
    int  rsp_stall_pct;
    bit  hold_req;
    int  stall_cycles;
    int  err_count;
    int  n_cmd, n_rsp, n_cfg;
    int  n_pool_full, n_cache_full, n_invalid, n_hits;

    // Clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic int owner_lookup(logic [ID_W-1:0] id);
        for (int i = 0; i < ACTIVE_SLOTS; i++)
            if (bound_used[i] && bound_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic int key_lookup(logic [KEY_W-1:0] key);
        for (int i = 0; i < CACHED_SLOTS; i++)
            if (snap_used[i] && snap_key[i] == key)
                return i;
        return -1;
    endfunction

    // Pool behavior: updates the shadow state and returns the response word
    function automatic t_rsp_word pool_step(t_cmd_word c);
        t_rsp_word r;
        int        hit;
        int        s;
        r   = '0;
        hit = -1;
        case (c.opcode)
            OP_ACQUIRE: begin
                hit = owner_lookup(c.sequence_id);
                if (hit >= 0) begin
                    r.found = 1'b1;
                    r.slot  = SLOT_W'(hit);
                end else if (free_top == 0) begin
                    r.status = STS_FULL;
                    n_pool_full++;
                end else begin
                    free_top--;
                    s = int'(free_slots[free_top]);
                    bound_used[s]  = 1'b1;
                    bound_id[s]    = c.sequence_id;
                    r.found        = 1'b1;
                    r.slot         = SLOT_W'(s);
                    r.storage_op   = SOP_ZERO;
                    r.storage_dst  = SLOT_W'(s);
                end
            end
            OP_RELEASE: begin
                hit = owner_lookup(c.sequence_id);
                if (hit >= 0) begin
                    bound_used[hit] = 1'b0;
                    bound_id[hit]   = '0;
                    if (free_top < ACTIVE_SLOTS) begin
                        free_slots[free_top] = ACT_W'(hit);
                        free_top++;
                    end
                    r.found = 1'b1;
                    r.slot  = SLOT_W'(hit);
                end
            end
            OP_FIND_ACTIVE: begin
                hit = owner_lookup(c.sequence_id);
                if (hit >= 0) begin
                    r.found = 1'b1;
                    r.slot  = SLOT_W'(hit);
                end
            end
            OP_SNAPSHOT: begin
                if (c.target_slot >= ACTIVE_SLOTS || c.frontier_index >= depth_cfg) begin
                    r.status = STS_INVALID;
                end else begin
                    hit = key_lookup(c.prefix_key);
                    if (hit >= 0) begin
                        r.found = 1'b1;
                        r.slot  = SLOT_W'(ACTIVE_SLOTS + hit);
                    end else if (snap_left == 0) begin
                        r.status = STS_FULL;
                        n_cache_full++;
                    end else begin
                        snap_left--;
                        snap_used[snap_left] = 1'b1;
                        snap_key[snap_left]  = c.prefix_key;
                        r.found       = 1'b1;
                        r.slot        = SLOT_W'(ACTIVE_SLOTS + snap_left);
                        r.storage_op  = SOP_COPY;
                        r.storage_src = SLOT_W'(c.target_slot);
                        r.storage_dst = SLOT_W'(ACTIVE_SLOTS + snap_left);
                    end
                end
            end
            OP_RESTORE: begin
                if (c.target_slot < ACTIVE_SLOTS)
                    hit = key_lookup(c.prefix_key);
                if (hit < 0) begin
                    r.status = STS_INVALID;
                end else begin
                    r.found       = 1'b1;
                    r.slot        = SLOT_W'(ACTIVE_SLOTS + hit);
                    r.storage_op  = SOP_COPY;
                    r.storage_src = SLOT_W'(ACTIVE_SLOTS + hit);
                    r.storage_dst = SLOT_W'(c.target_slot);
                end
            end
            OP_FIND_CACHED: begin
                hit = key_lookup(c.prefix_key);
                if (hit >= 0) begin
                    r.found = 1'b1;
                    r.slot  = SLOT_W'(ACTIVE_SLOTS + hit);
                end
            end
            default: r.status = STS_INVALID;
        endcase
        if (r.status == STS_INVALID)
            n_invalid++;
        if (hit >= 0)
            n_hits++;
        return r;
    endfunction

    function automatic t_cmd_word mk_cmd(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                         logic [KEY_W-1:0] key, logic [FR_W-1:0] fr,
                                         logic [TGT_W-1:0] tgt);
        t_cmd_word c;
        c.opcode         = op;
        c.sequence_id    = id;
        c.prefix_key     = key;
        c.frontier_index = fr;
        c.target_slot    = tgt;
        return c;
    endfunction

    function automatic t_rsp_word mk_rsp(logic [STS_W-1:0] st, int fd, int sl,
                                         logic [SOP_W-1:0] op, int src, int dst);
        t_rsp_word r;
        r.status      = st;
        r.found       = (fd != 0);
        r.slot        = SLOT_W'(sl);
        r.storage_op  = op;
        r.storage_src = SLOT_W'(src);
        r.storage_dst = SLOT_W'(dst);
        return r;
    endfunction

    function automatic void add_row(t_cmd_word c, int fixed, t_rsp_word e);
        t_dir_row row;
        row.cmd   = c;
        row.fixed = (fixed != 0);
        row.rsp   = e;
        dir_rows  = {dir_rows, row};
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Random command: mostly ids and keys from small pools so lookups hit
    function automatic t_cmd_word rand_cmd(bit churn);
        t_cmd_word c;
        int        pick;
        c.sequence_id = id_pool[$urandom_range(0, POOL_IDS - 1)];
        c.prefix_key  = key_pool[$urandom_range(0, POOL_KEYS - 1)];
        case ($urandom_range(0, 5))
            0:       c.frontier_index = '0;
            1:       c.frontier_index = depth_cfg - 8'd1;
            2:       c.frontier_index = depth_cfg;
            3, 4:    c.frontier_index = FR_W'($urandom_range(0, int'(depth_cfg)));
            default: c.frontier_index = FR_W'($urandom);
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 85)
            c.target_slot = TGT_W'($urandom_range(0, ACTIVE_SLOTS - 1));
        else if (pick < 95)
            c.target_slot = TGT_W'($urandom_range(ACTIVE_SLOTS, 255));
        else
            c.target_slot = '1;
        pick = $urandom_range(0, 99);
        if (churn ? pick < 20 : pick < 35)
            c.opcode = OP_ACQUIRE;
        else if (pick < 48)
            c.opcode = OP_RELEASE;
        else if (pick < 58)
            c.opcode = OP_FIND_ACTIVE;
        else if (pick < 73)
            c.opcode = OP_SNAPSHOT;
        else if (pick < 85)
            c.opcode = OP_RESTORE;
        else if (pick < 93)
            c.opcode = OP_FIND_CACHED;
        else
            c = mk_cmd(OP_W'($urandom_range(0, 7)), $urandom, {$urandom, $urandom},
                       FR_W'($urandom), TGT_W'($urandom));
        return c;
    endfunction

    // Offer one command word, with an optional random gap first
    task automatic send_cmd(t_cmd_word c, bit fixed, t_rsp_word e);
        if (cmd_gap_pct != 0 && $urandom_range(1, 100) <= cmd_gap_pct) begin
            cmd_ch.valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        cmd_ch.valid = 1'b1;
        cmd_ch.data  = c;
        row_fixed    = fixed;
        row_rsp      = e;
        do @(posedge clk); while (!cmd_ch.ready);
        @(negedge clk);
    endtask

    task automatic write_depth(logic [FR_W-1:0] v);
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = v;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Let every outstanding response drain, then give the block its worst-case latency
    task automatic settle();
        cmd_ch.valid = 1'b0;
        row_fixed    = 1'b0;
        while (pool_rsp_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Response sink: random stalls, plus one long hold-off on request
    initial begin : rsp_sink
        rsp_ch.ready = 1'b0;
        while (!rst_n) @(negedge clk);
        forever begin
            if (hold_req) begin
                rsp_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end else if (rsp_stall_pct != 0 && $urandom_range(1, 100) <= rsp_stall_pct) begin
                rsp_ch.ready = 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end else begin
                rsp_ch.ready = 1'b1;
                @(negedge clk);
            end
        end
    end

    // Handshake monitor, response checker and watchdog
    always @(posedge clk) begin : monitor
        t_rsp_word want;
        bit        moved;
        if (rst_n) begin
            moved = 1'b0;
            if (rsp_ch.valid && rsp_ch.ready) begin
                moved = 1'b1;
                n_rsp++;
                if (pool_rsp_q.size() == 0) begin
                    err_count++;
                    $display("%0t: response word with nothing expected, expected none, actual %h",
                             $time, rsp_ch.data);
                end else begin
                    want = pool_rsp_q.pop_front();
                    check_field("status", 8'(want.status), 8'(rsp_ch.data.status));
                    check_field("found", 8'(want.found), 8'(rsp_ch.data.found));
                    check_field("slot", 8'(want.slot), 8'(rsp_ch.data.slot));
                    check_field("storage_op", 8'(want.storage_op),
                                8'(rsp_ch.data.storage_op));
                    check_field("storage_src", 8'(want.storage_src),
                                8'(rsp_ch.data.storage_src));
                    check_field("storage_dst", 8'(want.storage_dst),
                                8'(rsp_ch.data.storage_dst));
                end
            end
            if (cmd_ch.valid && cmd_ch.ready) begin
                moved = 1'b1;
                n_cmd++;
                want = pool_step(cmd_ch.data);
                pool_rsp_q = {pool_rsp_q, (row_fixed ? row_rsp : want)};
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                moved = 1'b1;
                n_cfg++;
                depth_cfg = cfg_ch.data;
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin : stim
        logic [KEY_W-1:0] ones_key;
        logic [ID_W-1:0]  ones_id;
        bit               churn;
        logic [FR_W-1:0]  depth_set [5];

        rst_n         = 1'b0;
        cmd_ch.valid  = 1'b0;
        cmd_ch.data   = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        row_fixed     = 1'b0;
        row_rsp       = '0;
        hold_req      = 1'b0;
        cmd_gap_pct   = 0;
        rsp_stall_pct = 0;
        stall_cycles  = 0;
        err_count     = 0;
        n_cmd = 0; n_rsp = 0; n_cfg = 0;
        n_pool_full = 0; n_cache_full = 0; n_invalid = 0; n_hits = 0;

        depth_cfg = FRONTIER_RESET;
        for (int i = 0; i < ACTIVE_SLOTS; i++) begin
            free_slots[i] = ACT_W'(i);
            bound_used[i] = 1'b0;
            bound_id[i]   = '0;
        end
        free_top = ACTIVE_SLOTS;
        for (int i = 0; i < CACHED_SLOTS; i++) begin
            snap_used[i] = 1'b0;
            snap_key[i]  = '0;
        end
        snap_left = CACHED_SLOTS;

        ones_key = '1;
        ones_id  = '1;
        id_pool[0]  = '0;
        id_pool[1]  = ones_id;
        key_pool[0] = '0;
        key_pool[1] = ones_key;
        for (int i = 2; i < POOL_IDS; i++)
            id_pool[i] = $urandom;
        for (int i = 2; i < POOL_KEYS; i++)
            key_pool[i] = {$urandom, $urandom};

        // Directed table: empty lookups, bound and unbound ids, range errors, cache reuse
        add_row(mk_cmd(OP_FIND_ACTIVE, '0, '0, '0, '0), 1,
                mk_rsp(STS_OK, 0, 0, SOP_NONE, 0, 0));
        add_row(mk_cmd(OP_FIND_CACHED, '0, '0, '0, '0), 1,
                mk_rsp(STS_OK, 0, 0, SOP_NONE, 0, 0));
        add_row(mk_cmd(OP_RELEASE, ones_id, '0, '0, '0), 1,
                mk_rsp(STS_OK, 0, 0, SOP_NONE, 0, 0));
        add_row(mk_cmd(OP_ACQUIRE, '0, '0, '0, '0), 1,
                mk_rsp(STS_OK, 1, 15, SOP_ZERO, 0, 15));
        add_row(mk_cmd(OP_ACQUIRE, ones_id, ones_key, '1, '1), 1,
                mk_rsp(STS_OK, 1, 14, SOP_ZERO, 0, 14));
        add_row(mk_cmd(OP_ACQUIRE, '0, '0, '0, '0), 1,
                mk_rsp(STS_OK, 1, 15, SOP_NONE, 0, 0));
        add_row(mk_cmd(OP_FIND_ACTIVE, ones_id, '0, '0, '0), 1,
                mk_rsp(STS_OK, 1, 14, SOP_NONE, 0, 0));
        add_row(mk_cmd(OP_SNAPSHOT, '0, '0, '0, 8'd16), 1,
                mk_rsp(STS_INVALID, 0, 0, SOP_NONE, 0, 0));
        add_row(mk_cmd(OP_SNAPSHOT, '0, '0, '0, '1), 1,
                mk_rsp(STS_INVALID, 0, 0, SOP_NONE, 0, 0));
        add_row(mk_cmd(OP_SNAPSHOT, '0, '0, 8'd16, '0), 1,
                mk_rsp(STS_INVALID, 0, 0, SOP_NONE, 0, 0));
        add_row(mk_cmd(OP_SNAPSHOT, '0, '0, '1, '0), 1,
                mk_rsp(STS_INVALID, 0, 0, SOP_NONE, 0, 0));
        add_row(mk_cmd(OP_SNAPSHOT, '0, ones_key, 8'd15, 8'd15), 1,
                mk_rsp(STS_OK, 1, 31, SOP_COPY, 15, 31));
        add_row(mk_cmd(OP_SNAPSHOT, '0, ones_key, '0, '0), 1,
                mk_rsp(STS_OK, 1, 31, SOP_NONE, 0, 0));
        add_row(mk_cmd(OP_SNAPSHOT, ones_id, '0, '0, '0), 1,
                mk_rsp(STS_OK, 1, 30, SOP_COPY, 0, 30));
        add_row(mk_cmd(OP_RESTORE, '0, '0, '0, 8'd15), 1,
                mk_rsp(STS_OK, 1, 30, SOP_COPY, 30, 15));
        add_row(mk_cmd(OP_RESTORE, '0, '0, '0, 8'd16), 1,
                mk_rsp(STS_INVALID, 0, 0, SOP_NONE, 0, 0));
        add_row(mk_cmd(OP_RESTORE, '0, 64'h5555_5555_5555_5555, '0, '0), 1,
                mk_rsp(STS_INVALID, 0, 0, SOP_NONE, 0, 0));
        add_row(mk_cmd(OP_FIND_CACHED, '0, ones_key, '0, '0), 1,
                mk_rsp(STS_OK, 1, 31, SOP_NONE, 0, 0));
        add_row(mk_cmd(OP_RSVD_A, ones_id, ones_key, '1, '1), 1,
                mk_rsp(STS_INVALID, 0, 0, SOP_NONE, 0, 0));
        add_row(mk_cmd(OP_RSVD_B, '0, '0, '0, '0), 1,
                mk_rsp(STS_INVALID, 0, 0, SOP_NONE, 0, 0));
        add_row(mk_cmd(OP_RELEASE, '0, '0, '0, '0), 1,
                mk_rsp(STS_OK, 1, 15, SOP_NONE, 0, 0));
        add_row(mk_cmd(OP_RELEASE, ones_id, '0, '0, '0), 1,
                mk_rsp(STS_OK, 1, 14, SOP_NONE, 0, 0));
        add_row(mk_cmd(OP_ACQUIRE, 32'h1234_5678, '0, '0, '0), 1,
                mk_rsp(STS_OK, 1, 14, SOP_ZERO, 0, 14));
        add_row(mk_cmd(OP_FIND_ACTIVE, $urandom, '0, '0, '0), 0, '0);
        add_row(mk_cmd(OP_RESTORE, '0, ones_key, '0, 8'd3), 0, '0);

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_cmd(dir_rows[i].cmd, dir_rows[i].fixed, dir_rows[i].rsp);
        settle();

        // Random phases over frontier depth settings; the last one runs without idling
        depth_set[0] = '1;
        depth_set[1] = '0;
        depth_set[2] = 8'd1;
        depth_set[3] = FR_W'($urandom_range(2, 254));
        depth_set[4] = FRONTIER_RESET;
        for (int ph = 0; ph < 5; ph++) begin
            write_depth(depth_set[ph]);
            churn = ph[0];
            case (ph)
                0:       begin cmd_gap_pct = 20; rsp_stall_pct = 20; end
                1:       begin cmd_gap_pct = 0;  rsp_stall_pct = 0;  end
                2:       begin cmd_gap_pct = 30; rsp_stall_pct = 10; end
                3:       begin cmd_gap_pct = 10; rsp_stall_pct = 30; end
                default: begin cmd_gap_pct = 0;  rsp_stall_pct = 0;  end
            endcase
            if (ph == 0) begin
                @(posedge clk);
                hold_req = 1'b1;
                @(negedge clk);
            end
            repeat (PHASE_ITEMS)
                send_cmd(rand_cmd(churn), 1'b0, '0);
            settle();
        end

        if (pool_rsp_q.size() != 0) begin
            err_count++;
            $display("%0t: %0d responses never arrived", $time, pool_rsp_q.size());
        end

        $display("Ran %0d commands, checked %0d responses, %0d frontier depth writes",
                 n_cmd, n_rsp, n_cfg);
        $display("Lookup hits %0d, pool exhausted %0d, cache exhausted %0d, rejected %0d",
                 n_hits, n_pool_full, n_cache_full, n_invalid);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
